// ===== rtl/core/iaf_pkg.sv =====
// Shared constants, operation codes and helper functions for the integer ASCII formatter.
package iaf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int WIDTH_BITS     = 7;
  localparam int CHAR_BITS      = 8;

  typedef logic [1:0] iaf_cmd_t;
  localparam iaf_cmd_t CMD_SDEC  = 2'd0;
  localparam iaf_cmd_t CMD_UDEC  = 2'd1;
  localparam iaf_cmd_t CMD_HEX_L = 2'd2;
  localparam iaf_cmd_t CMD_HEX_U = 2'd3;

  typedef logic [2:0] iaf_op_t;
  localparam iaf_op_t OP_HOLD     = 3'd0;
  localparam iaf_op_t OP_LOAD_HEX = 3'd1;
  localparam iaf_op_t OP_LOAD_DEC = 3'd2;
  localparam iaf_op_t OP_DABBLE   = 3'd3;
  localparam iaf_op_t OP_SHIFT    = 3'd4;

  typedef logic [CHAR_BITS-1:0] iaf_char_t;
  localparam iaf_char_t CH_SPACE = 8'h20;
  localparam iaf_char_t CH_ZERO  = 8'h30;
  localparam iaf_char_t CH_MINUS = 8'h2d;
  localparam iaf_char_t CH_LC_A  = 8'h61;
  localparam iaf_char_t CH_UC_A  = 8'h41;

  // digit slots needed to hold either the decimal or the hex form
  function automatic int ndig(input int vb);
    int dec;
    int hex;
    dec = ((vb * 1233) >> 12) + 1;
    hex = (vb + 3) >> 2;
    return (dec > hex) ? dec : hex;
  endfunction

  function automatic iaf_char_t digit_char(input logic [3:0] d, input logic upper);
    iaf_char_t c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_UC_A : CH_LC_A) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/iaf_digit_unit.sv =====
// Digit register with one add-3 adjuster per digit: hex loading, binary to BCD conversion and digit shifting.
module iaf_digit_unit import iaf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  iaf_op_t               op,
  input  logic [VALUE_BITS-1:0] load_value,
  output logic [3:0]            top_digit
);

  localparam int NDIG = ndig(VALUE_BITS);
  localparam int DW   = NDIG * 4;

  logic [DW-1:0]         dig;
  logic [DW-1:0]         dig_next;
  logic [VALUE_BITS-1:0] bin;
  logic [VALUE_BITS-1:0] bin_next;
  logic [DW-1:0]         adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3 : dig[i*4 +: 4];
    end
  end

  always_comb begin
    dig_next = dig;
    bin_next = bin;
    case (op)
      OP_LOAD_HEX: dig_next = DW'(load_value);
      OP_LOAD_DEC: begin
        dig_next = '0;
        bin_next = load_value;
      end
      OP_DABBLE: begin
        dig_next = {adj[DW-2:0], bin[VALUE_BITS-1]};
        bin_next = {bin[VALUE_BITS-2:0], 1'b0};
      end
      OP_SHIFT: dig_next = {dig[DW-5:0], 4'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
    bin <= bin_next;
  end

  assign top_digit = dig[DW-1 -: 4];

endmodule

// ===== rtl/core/integer_ascii_formatter.sv =====
// Top level: printf-style integer to ASCII converter with sequencer and character output.
//
// A request (cmd, value, pad_width, zero_pad) is taken at a rising edge with start high
// and busy low. busy then stays high until the final character has been issued.
// Characters leave one per cycle on ascii_char with strobe high for exactly one cycle;
// last marks the final character of a conversion. The receiver cannot stall.
// A decimal request first runs shift/add-3 conversion (hex skips it), then a scan strips
// leading zero digits, and then the characters are issued.
// The shared digit register and its add-3 unit set the pace; a new request can be taken
// while the final character is on ascii_char with last high.
// pad_width above MAX_WIDTH saturates at MAX_WIDTH. Reset returns the sequencer to idle
// and drops strobe; any conversion in progress is abandoned.
module integer_ascii_formatter import iaf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [31:0]           value,
  input  logic [WIDTH_BITS-1:0] pad_width,
  input  logic                  zero_pad,
  output logic                  strobe,
  output logic [CHAR_BITS-1:0]  ascii_char,
  output logic                  last
);

  localparam int NDIG = ndig(VALUE_BITS);
  localparam int NW   = $clog2(NDIG + 1);
  localparam int CW   = $clog2(VALUE_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         cnt;
  logic [NW-1:0]         nd;
  logic [WIDTH_BITS-1:0] w;
  logic [WIDTH_BITS-1:0] pad_cnt;
  logic                  neg;
  logic                  zpad;
  logic                  upper;
  logic                  sign_done;

  logic                  accept;
  logic [VALUE_BITS-1:0] vb;
  logic                  vneg;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            top_digit;
  iaf_op_t               op;
  logic                  emit_digit;
  logic [WIDTH_BITS-1:0] text_len;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign vb       = VALUE_BITS'(value);
  assign vneg     = (cmd == CMD_SDEC) && vb[VALUE_BITS-1];
  assign mag      = vneg ? (~vb + 1'b1) : vb;
  assign text_len = WIDTH_BITS'(nd) + {{(WIDTH_BITS-1){1'b0}}, neg};

  assign emit_digit = (state == ST_EMIT) && (pad_cnt == '0) && !(neg && !sign_done);

  always_comb begin
    op = OP_HOLD;
    case (state)
      ST_IDLE: if (accept) op = (cmd == CMD_HEX_L || cmd == CMD_HEX_U) ? OP_LOAD_HEX
                                                                     : OP_LOAD_DEC;
      ST_CONV: op = OP_DABBLE;
      ST_SCAN: if (nd > NW'(1) && top_digit == 4'd0) op = OP_SHIFT;
      ST_EMIT: if (emit_digit) op = OP_SHIFT;
      default: op = OP_HOLD;
    endcase
  end

  iaf_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .clk       (clk),
    .op        (op),
    .load_value(mag),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            neg       <= vneg;
            zpad      <= zero_pad;
            upper     <= (cmd == CMD_HEX_U);
            sign_done <= 1'b0;
            w         <= (pad_width > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                             : pad_width;
            nd        <= NW'(NDIG);
            cnt       <= CW'(VALUE_BITS);
            state     <= (cmd == CMD_HEX_L || cmd == CMD_HEX_U) ? ST_SCAN : ST_CONV;
          end
        end
        ST_CONV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (nd > NW'(1) && top_digit == 4'd0) begin
            nd <= nd - 1'b1;
          end else begin
            pad_cnt <= (w > text_len) ? w - text_len : '0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          last   <= 1'b0;
          if (neg && zpad && !sign_done) begin
            ascii_char <= CH_MINUS;
            sign_done  <= 1'b1;
          end else if (pad_cnt != '0) begin
            ascii_char <= zpad ? CH_ZERO : CH_SPACE;
            pad_cnt    <= pad_cnt - 1'b1;
          end else if (neg && !sign_done) begin
            ascii_char <= CH_MINUS;
            sign_done  <= 1'b1;
          end else begin
            ascii_char <= digit_char(top_digit, upper);
            nd         <= nd - 1'b1;
            if (nd == NW'(1)) begin
              last  <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_EMIT)
    else $error("character issued outside emit phase");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high after final character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("transaction accepted but busy not raised");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> nd != '0)
    else $error("emit phase with no digits left");

endmodule
